### design/sdms_pkg.sv
// ----------------------------------------------------------------------------
// sdms_pkg
// Shared types and constants for the stereo decorrelation mode selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdms_pkg;

    localparam int SAMPLE_W   = 32;             // channel sample width
    localparam int MAG_W      = SAMPLE_W;       // |L|, |R|, |mid|
    localparam int SIDE_MAG_W = SAMPLE_W + 1;   // |L - R|
    localparam int INC_W      = SAMPLE_W + 2;   // per-pair cost of one mode
    localparam int SUM_W      = 50;             // running cost sum
    localparam int NUM_MODES  = 4;
    localparam int MODE_W     = 2;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_INDEPENDENT = 2'd0,
        MODE_LEFT_SIDE   = 2'd1,
        MODE_RIGHT_SIDE  = 2'd2,
        MODE_MID_SIDE    = 2'd3
    } t_mode;

    // Per-pair cost of each mode plus the end-of-block mark
    typedef struct packed {
        logic [NUM_MODES-1:0][INC_W-1:0] inc;
        logic                            last;
    } t_incr;

endpackage

`default_nettype wire

### design/stereo_decorrelation_mode_select.sv
// ----------------------------------------------------------------------------
// stereo_decorrelation_mode_select
// Picks the cheapest stereo decorrelation mode for each block of sample pairs.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                  payload
//  --------  ---  -------------------------  --------------------------------
//  s_axis    in   s_axis_tvalid/tready       tdata: left, right; tlast: end
//  m_axis    out  m_axis_tvalid/tready       tdata: best_mode
//
//  One pair per cycle sustained while m_axis takes results. A pair passes the
//  front's magnitude stage, then its mode-cost stage, then waits in a 4-entry
//  queue; the back folds one pair per cycle into four 50-bit saturating sums.
//  A block's result goes to the snapshot, then to the result register on
//  m_axis. Reset is synchronous, active low, and clears sums and all valid
//  flags. A stalled m_axis holds the result register, then the snapshot; the
//  queue and front stages fill behind the next last pair; s_axis_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stereo_decorrelation_mode_select (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [31:0] left_sample, [63:32] right_sample
    input  wire logic        s_axis_tlast,   // last_sample
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // [1:0] best_mode, [7:2] zero
);
    import sdms_pkg::*;

    logic              front_vld, front_rdy;
    t_incr             front_incr;
    logic              q_vld, q_rdy;
    t_incr             q_incr;
    logic [QCNT_W-1:0] q_count;
    logic              snap_vld;
    t_mode             best_mode;

    sdms_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_axis_tvalid),
        .o_rdy   (s_axis_tready),
        .i_left  (s_axis_tdata[SAMPLE_W-1:0]),
        .i_right (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .i_last  (s_axis_tlast),
        .o_vld   (front_vld),
        .i_rdy   (front_rdy),
        .o_incr  (front_incr)
    );

    sdms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (front_vld),
        .o_rdy   (front_rdy),
        .i_data  (front_incr),
        .o_vld   (q_vld),
        .i_rdy   (q_rdy),
        .o_data  (q_incr),
        .o_count (q_count)
    );

    sdms_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (q_vld),
        .o_rdy      (q_rdy),
        .i_incr     (q_incr),
        .o_snap_vld (snap_vld),
        .o_vld      (m_axis_tvalid),
        .i_rdy      (m_axis_tready),
        .o_mode     (best_mode)
    );

    assign m_axis_tdata = {{(8 - MODE_W){1'b0}}, best_mode};

    // Queue occupancy stays within its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // Input backpressure only arises from a full queue
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (q_count == QCNT_W'(QUEUE_DEPTH)))
        else $error("s_axis_tready low with room in queue");

    // A new result is always preceded by a judged snapshot
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(snap_vld))
        else $error("result without snapshot");

endmodule

`default_nettype wire

### design/sdms_front.sv
// ----------------------------------------------------------------------------
// sdms_front
// Accepts sample pairs, forms magnitudes, then the per-mode costs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdms_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_vld,
    output logic                                o_rdy,
    input  wire logic [sdms_pkg::SAMPLE_W-1:0]  i_left,
    input  wire logic [sdms_pkg::SAMPLE_W-1:0]  i_right,
    input  wire logic                           i_last,
    output logic                                o_vld,
    input  wire logic                           i_rdy,
    output sdms_pkg::t_incr                     o_incr
);
    import sdms_pkg::*;

    // stage 1: magnitudes
    logic                  r_s1_vld;
    logic [MAG_W-1:0]      r_mag_l, r_mag_r, r_mag_m;
    logic [SIDE_MAG_W-1:0] r_mag_s;
    logic                  r_s1_last;
    // stage 2: per-mode costs
    logic                  r_s2_vld;
    t_incr                 r_incr;

    logic                  s1_adv, s2_adv;
    logic [SAMPLE_W:0]     l_ext, r_ext, side, side_neg, total, l_neg, r_neg, mid_neg;
    logic [SAMPLE_W-1:0]   mid;
    logic [MAG_W-1:0]      n_mag_l, n_mag_r, n_mag_m;
    logic [SIDE_MAG_W-1:0] n_mag_s;

    assign s2_adv = !r_s2_vld || i_rdy;
    assign s1_adv = !r_s1_vld || s2_adv;
    assign o_rdy  = s1_adv;
    assign o_vld  = r_s2_vld;
    assign o_incr = r_incr;

    always_comb begin
        l_ext    = {i_left[SAMPLE_W-1], i_left};
        r_ext    = {i_right[SAMPLE_W-1], i_right};
        l_neg    = -l_ext;
        r_neg    = -r_ext;
        side     = l_ext - r_ext;
        side_neg = r_ext - l_ext;
        total    = l_ext + r_ext;
        mid      = total[SAMPLE_W:1];           // floor via arithmetic shift
        mid_neg  = -{mid[SAMPLE_W-1], mid};
        n_mag_l  = i_left[SAMPLE_W-1]  ? l_neg[MAG_W-1:0] : i_left;
        n_mag_r  = i_right[SAMPLE_W-1] ? r_neg[MAG_W-1:0] : i_right;
        n_mag_s  = side[SAMPLE_W]      ? side_neg : side;
        n_mag_m  = mid[SAMPLE_W-1]     ? mid_neg[MAG_W-1:0] : mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_vld <= i_vld;
            end
            if (s2_adv) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && i_vld) begin
            r_mag_l   <= n_mag_l;
            r_mag_r   <= n_mag_r;
            r_mag_s   <= n_mag_s;
            r_mag_m   <= n_mag_m;
            r_s1_last <= i_last;
        end
        if (s2_adv && r_s1_vld) begin
            r_incr.inc[MODE_INDEPENDENT] <= INC_W'(r_mag_l) + INC_W'(r_mag_r);
            r_incr.inc[MODE_LEFT_SIDE]   <= INC_W'(r_mag_l) + INC_W'(r_mag_s);
            r_incr.inc[MODE_RIGHT_SIDE]  <= INC_W'(r_mag_s) + INC_W'(r_mag_r);
            r_incr.inc[MODE_MID_SIDE]    <= INC_W'(r_mag_m) + INC_W'(r_mag_s);
            r_incr.last                  <= r_s1_last;
        end
    end

endmodule

`default_nettype wire

### design/sdms_queue.sv
// ----------------------------------------------------------------------------
// sdms_queue
// Short FIFO of per-mode costs between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdms_queue (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_vld,
    output logic                            o_rdy,
    input  sdms_pkg::t_incr                 i_data,
    output logic                            o_vld,
    input  wire logic                       i_rdy,
    output sdms_pkg::t_incr                 o_data,
    output logic [sdms_pkg::QCNT_W-1:0]     o_count
);
    import sdms_pkg::*;

    t_incr             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push, pop;

    assign o_rdy   = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_vld   = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign push    = i_vld && o_rdy;
    assign pop     = i_rdy && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### design/sdms_back.sv
// ----------------------------------------------------------------------------
// sdms_back
// Saturating cost accumulators, end-of-block judge and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdms_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_vld,
    output logic                            o_rdy,
    input  sdms_pkg::t_incr                 i_incr,
    output logic                            o_snap_vld,
    output logic                            o_vld,
    input  wire logic                       i_rdy,
    output sdms_pkg::t_mode                 o_mode
);
    import sdms_pkg::*;

    logic [SUM_W-1:0] r_sum  [NUM_MODES];
    logic [SUM_W-1:0] r_snap [NUM_MODES];
    logic [SUM_W-1:0] n_sum  [NUM_MODES];
    logic             r_snap_vld;
    logic             r_out_vld;
    t_mode            r_mode;

    logic             out_load, snap_free, pop;
    logic [SUM_W:0]   raw [NUM_MODES];
    logic             pick_b, pick_d, pick_hi;
    logic [SUM_W-1:0] min_ab, min_cd;
    t_mode            mode_ab, mode_cd, n_mode;

    assign out_load   = !r_out_vld || i_rdy;
    assign snap_free  = !r_snap_vld || out_load;
    // a last item also needs room in the snapshot
    assign pop        = i_vld && (!i_incr.last || snap_free);
    assign o_rdy      = !i_incr.last || snap_free;
    assign o_snap_vld = r_snap_vld;
    assign o_vld      = r_out_vld;
    assign o_mode     = r_mode;

    always_comb begin
        for (int i = 0; i < NUM_MODES; i++) begin
            raw[i]   = {1'b0, r_sum[i]} + (SUM_W+1)'(i_incr.inc[i]);
            n_sum[i] = raw[i][SUM_W] ? SUM_MAX : raw[i][SUM_W-1:0];
        end
    end

    // Two-level minimum; lower mode wins on equal sums
    always_comb begin
        pick_b  = r_snap[MODE_LEFT_SIDE] < r_snap[MODE_INDEPENDENT];
        pick_d  = r_snap[MODE_MID_SIDE] < r_snap[MODE_RIGHT_SIDE];
        min_ab  = pick_b ? r_snap[MODE_LEFT_SIDE] : r_snap[MODE_INDEPENDENT];
        mode_ab = pick_b ? MODE_LEFT_SIDE : MODE_INDEPENDENT;
        min_cd  = pick_d ? r_snap[MODE_MID_SIDE] : r_snap[MODE_RIGHT_SIDE];
        mode_cd = pick_d ? MODE_MID_SIDE : MODE_RIGHT_SIDE;
        pick_hi = min_cd < min_ab;
        n_mode  = pick_hi ? mode_cd : mode_ab;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_MODES; i++) begin
                r_sum[i] <= '0;
            end
            r_snap_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (pop) begin
                for (int i = 0; i < NUM_MODES; i++) begin
                    r_sum[i] <= i_incr.last ? '0 : n_sum[i];
                end
            end
            if (snap_free) begin
                r_snap_vld <= pop && i_incr.last;
            end
            if (out_load) begin
                r_out_vld <= r_snap_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_incr.last) begin
            for (int i = 0; i < NUM_MODES; i++) begin
                r_snap[i] <= n_sum[i];
            end
        end
        if (out_load && r_snap_vld) begin
            r_mode <= n_mode;
        end
    end

endmodule

`default_nettype wire
